/* hw/rtl/imapcp_pkg.sv */
// ----------------------------------------------------------------------------
// IMAP command line parser package
// Parse phase codes, event codes, command codes and small helper functions
// shared by the parser RTL.
// ----------------------------------------------------------------------------
package imapcp_pkg;

   // Widths of the positions, the letter store and the argument count.
   localparam int POS_BITS    = 16;
   localparam int MAX_LETTERS = 10;
   localparam int CNT_BITS    = 4;
   localparam int MAX_ARGS    = 3;

   typedef logic [POS_BITS-1:0]            pos_type;
   typedef logic [MAX_LETTERS-1:0][7:0]    letters_type;

   localparam pos_type POS_MAX = {POS_BITS{1'b1}};

   // Parse phases.
   localparam logic [3:0] PH_TAG       = 4'd0;
   localparam logic [3:0] PH_PRE_CMD   = 4'd1;
   localparam logic [3:0] PH_CMD       = 4'd2;
   localparam logic [3:0] PH_PRE_ARG   = 4'd3;
   localparam logic [3:0] PH_ARG       = 4'd4;
   localparam logic [3:0] PH_LIT_COUNT = 4'd5;
   localparam logic [3:0] PH_LIT_OPEN  = 4'd6;
   localparam logic [3:0] PH_LIT_DATA  = 4'd7;
   localparam logic [3:0] PH_LIT_END   = 4'd8;
   localparam logic [3:0] PH_ALMOST    = 4'd9;

   // Event kinds on the result channel.
   localparam logic [1:0] EV_ARG      = 2'd0;
   localparam logic [1:0] EV_LINE     = 2'd1;
   localparam logic [1:0] EV_INVALID  = 2'd2;
   localparam logic [1:0] EV_CONTINUE = 2'd3;

   // Command codes.
   localparam logic [1:0] CMD_NOOP       = 2'd0;
   localparam logic [1:0] CMD_LOGIN      = 2'd1;
   localparam logic [1:0] CMD_LOGOUT     = 2'd2;
   localparam logic [1:0] CMD_CAPABILITY = 2'd3;

   // Special bytes.
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_SPACE  = 8'h20;
   localparam logic [7:0] BYTE_QUOTE  = 8'h22;
   localparam logic [7:0] BYTE_LBRACE = 8'h7B;
   localparam logic [7:0] BYTE_RBRACE = 8'h7D;
   localparam logic [7:0] BYTE_ZERO   = 8'h30;
   localparam logic [7:0] BYTE_NINE   = 8'h39;

   // The first letter sits at index 0, the low byte, so the spellings
   // below read backwards.
   localparam letters_type WORD_NOOP       = {48'h0, "poon"};
   localparam letters_type WORD_LOGIN      = {40'h0, "nigol"};
   localparam letters_type WORD_LOGOUT     = {32'h0, "tuogol"};
   localparam letters_type WORD_CAPABILITY = "ytilibapac";

   // Saturating increment of a line position.
   function automatic pos_type pos_inc(input pos_type v);
      pos_type r;
      r = (v == POS_MAX) ? POS_MAX : v + pos_type'(1);
      return r;
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      logic r;
      r = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
      return r;
   endfunction

   // Case-insensitive compare of the stored letters against one word.
   function automatic logic word_is(input letters_type letters,
                                    input logic [CNT_BITS-1:0] count,
                                    input letters_type word,
                                    input logic [CNT_BITS-1:0] len);
      logic ok;
      ok = (count == len);
      for (int i = 0; i < MAX_LETTERS; i++) begin
         if (CNT_BITS'(i) < len && ((letters[i] | 8'h20) != word[i])) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

/* hw/rtl/imap_command_line_parser_core.sv */
// ----------------------------------------------------------------------------
// IMAP command line parser core
// Byte-wide parser for IMAP command lines: tag, command and up to three
// plain, quoted or literal arguments, reported as events.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of the command stream enter on the req_ channel, one per transfer.
// Each byte yields zero or one event on the rsp_ channel: argument found,
// line complete, invalid line or literal continuation request. A transfer
// happens on a rising edge with valid high and stall low.
// A byte is held in the input register, parsed in a single pass, and its
// event appears from the result register. One byte is taken every cycle
// while the receiver does not stall; the rate is set by the single parse
// pass between the two registers.
// When the receiver stalls, the result register holds its event and the
// input register can still take one byte if it is empty; further bytes are
// then stalled until the event is taken.
// Reset (synchronous, active high) returns the parser to the tag phase
// with all line state cleared and sets max_literal_length to 65535.
// The csr_ port writes max_literal_length whenever csr_wr_en is high; the user
// must write it only while the parser is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module imap_command_line_parser_core (
   input  logic        clock,
   input  logic        reset,
   // Byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   // Event output channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [1:0]  rsp_command_code,
   output logic [15:0] rsp_tag_length,
   output logic        rsp_arg_valid,
   output logic [1:0]  rsp_arg_index,
   output logic [15:0] rsp_arg_offset,
   output logic [15:0] rsp_arg_length,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // Input register and result register.
   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    out_free;
   logic                    advance;

   logic                    rsp_valid_ff;
   logic [1:0]              ev_kind_ff;
   logic [1:0]              cmd_code_ff;
   logic [15:0]             tag_len_out_ff;
   logic                    arg_valid_ff;
   logic [1:0]              arg_index_ff;
   logic [15:0]             arg_offset_ff;
   logic [15:0]             arg_length_ff;

   // Configuration register.
   logic [15:0]             max_lit_ff;

   // Line state and its next values.
   logic [3:0]              phase_ff, phase_in;
   imapcp_pkg::pos_type     pos_ff, pos_in;
   imapcp_pkg::pos_type     tag_len_ff, tag_len_in;
   imapcp_pkg::letters_type letters_ff;
   logic [imapcp_pkg::CNT_BITS-1:0] letter_cnt_ff, letter_cnt_in;
   logic                    letter_wr;
   logic [1:0]              matched_ff, matched_in;
   logic                    quote_ff, quote_in;
   logic [15:0]             lit_rem_ff, lit_rem_in;
   imapcp_pkg::pos_type     arg_begin_ff, arg_begin_in;
   logic [1:0]              args_ff, args_in;

   // Event produced by the current byte.
   logic                    emit;
   logic [1:0]              ev_kind;
   logic                    ev_arg;
   imapcp_pkg::pos_type     ev_len;
   logic                    line_clear;

   // Helper values.
   imapcp_pkg::pos_type     pos_next;
   imapcp_pkg::pos_type     plain_len;
   imapcp_pkg::pos_type     lit_len;
   logic [19:0]             lit_value;
   logic                    match_hit;
   logic [1:0]              match_code;
   logic [1:0]              out_cmd;
   logic [7:0]              b;

   // Handshake: the input register advances when the result register is free.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign b         = in_byte_ff;

   // Position arithmetic.
   assign pos_next  = imapcp_pkg::pos_inc(pos_ff);
   assign plain_len = (pos_ff >= arg_begin_ff) ? pos_ff - arg_begin_ff : '0;
   assign lit_len   = (pos_next >= arg_begin_ff) ? pos_next - arg_begin_ff : '0;

   // Literal count times ten plus the new digit.
   assign lit_value = {1'b0, lit_rem_ff, 3'b000} + {3'b000, lit_rem_ff, 1'b0}
                    + {16'h0, b[3:0] - imapcp_pkg::BYTE_ZERO[3:0]};

   // Command word match against the stored letters.
   always_comb begin
      match_hit  = 1'b1;
      match_code = imapcp_pkg::CMD_NOOP;
      if (imapcp_pkg::word_is(letters_ff, letter_cnt_ff,
                              imapcp_pkg::WORD_NOOP, 4'd4)) begin
         match_code = imapcp_pkg::CMD_NOOP;
      end else if (imapcp_pkg::word_is(letters_ff, letter_cnt_ff,
                                       imapcp_pkg::WORD_LOGIN, 4'd5)) begin
         match_code = imapcp_pkg::CMD_LOGIN;
      end else if (imapcp_pkg::word_is(letters_ff, letter_cnt_ff,
                                       imapcp_pkg::WORD_LOGOUT, 4'd6)) begin
         match_code = imapcp_pkg::CMD_LOGOUT;
      end else if (imapcp_pkg::word_is(letters_ff, letter_cnt_ff,
                                       imapcp_pkg::WORD_CAPABILITY, 4'd10)) begin
         match_code = imapcp_pkg::CMD_CAPABILITY;
      end else begin
         match_hit = 1'b0;
      end
   end

   // Parse step for one byte.
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_next;
      tag_len_in    = tag_len_ff;
      letter_cnt_in = letter_cnt_ff;
      letter_wr     = 1'b0;
      matched_in    = matched_ff;
      quote_in      = quote_ff;
      lit_rem_in    = lit_rem_ff;
      arg_begin_in  = arg_begin_ff;
      args_in       = args_ff;
      emit          = 1'b0;
      ev_kind       = imapcp_pkg::EV_ARG;
      ev_arg        = 1'b0;
      ev_len        = '0;
      line_clear    = 1'b0;

      case (phase_ff)
         imapcp_pkg::PH_PRE_CMD: begin
            if (b == imapcp_pkg::BYTE_SPACE) begin
               phase_in = phase_ff;
            end else if (b == imapcp_pkg::BYTE_CR || b == imapcp_pkg::BYTE_LF) begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_INVALID;
               line_clear = 1'b1;
            end else begin
               // First letter goes to slot zero.
               letter_wr     = 1'b1;
               letter_cnt_in = 4'd1;
               phase_in      = imapcp_pkg::PH_CMD;
            end
         end

         imapcp_pkg::PH_CMD: begin
            if (b == imapcp_pkg::BYTE_SPACE || b == imapcp_pkg::BYTE_CR ||
                b == imapcp_pkg::BYTE_LF) begin
               if (!match_hit) begin
                  emit       = 1'b1;
                  ev_kind    = imapcp_pkg::EV_INVALID;
                  line_clear = 1'b1;
               end else begin
                  matched_in = match_code;
                  if (b == imapcp_pkg::BYTE_SPACE) begin
                     phase_in = imapcp_pkg::PH_PRE_ARG;
                  end else if (b == imapcp_pkg::BYTE_CR) begin
                     phase_in = imapcp_pkg::PH_ALMOST;
                  end else begin
                     emit       = 1'b1;
                     ev_kind    = imapcp_pkg::EV_LINE;
                     line_clear = 1'b1;
                  end
               end
            end else if (!imapcp_pkg::is_letter(b)) begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_INVALID;
               line_clear = 1'b1;
            end else begin
               // The count runs one past the store so that overlong words fail.
               letter_wr = (letter_cnt_ff < 4'(imapcp_pkg::MAX_LETTERS));
               if (letter_cnt_ff <= 4'(imapcp_pkg::MAX_LETTERS)) begin
                  letter_cnt_in = letter_cnt_ff + 4'd1;
               end
            end
         end

         imapcp_pkg::PH_PRE_ARG: begin
            if (b == imapcp_pkg::BYTE_SPACE) begin
               phase_in = phase_ff;
            end else if (b == imapcp_pkg::BYTE_CR) begin
               phase_in = imapcp_pkg::PH_ALMOST;
            end else if (b == imapcp_pkg::BYTE_LF) begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_LINE;
               line_clear = 1'b1;
            end else if (args_ff >= 2'(imapcp_pkg::MAX_ARGS)) begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_INVALID;
               line_clear = 1'b1;
            end else if (b == imapcp_pkg::BYTE_QUOTE) begin
               quote_in     = 1'b1;
               arg_begin_in = pos_next;
               phase_in     = imapcp_pkg::PH_ARG;
            end else if (b == imapcp_pkg::BYTE_LBRACE) begin
               lit_rem_in = '0;
               phase_in   = imapcp_pkg::PH_LIT_COUNT;
            end else begin
               arg_begin_in = pos_ff;
               phase_in     = imapcp_pkg::PH_ARG;
            end
         end

         imapcp_pkg::PH_ARG: begin
            if ((b == imapcp_pkg::BYTE_QUOTE && quote_ff) ||
                b == imapcp_pkg::BYTE_SPACE || b == imapcp_pkg::BYTE_CR ||
                b == imapcp_pkg::BYTE_LF) begin
               // Argument ends here.
               if (b == imapcp_pkg::BYTE_QUOTE) begin
                  quote_in = 1'b0;
               end
               if (args_ff < 2'd3) begin
                  args_in = args_ff + 2'd1;
               end
               emit   = 1'b1;
               ev_arg = 1'b1;
               ev_len = plain_len;
               if (b == imapcp_pkg::BYTE_LF) begin
                  ev_kind    = imapcp_pkg::EV_LINE;
                  line_clear = 1'b1;
               end else if (b == imapcp_pkg::BYTE_CR) begin
                  ev_kind  = imapcp_pkg::EV_ARG;
                  phase_in = imapcp_pkg::PH_ALMOST;
               end else begin
                  ev_kind  = imapcp_pkg::EV_ARG;
                  phase_in = imapcp_pkg::PH_PRE_ARG;
               end
            end
         end

         imapcp_pkg::PH_LIT_COUNT: begin
            if (b >= imapcp_pkg::BYTE_ZERO && b <= imapcp_pkg::BYTE_NINE) begin
               if (lit_value > {4'h0, max_lit_ff}) begin
                  emit       = 1'b1;
                  ev_kind    = imapcp_pkg::EV_INVALID;
                  line_clear = 1'b1;
               end else begin
                  lit_rem_in = lit_value[15:0];
               end
            end else if (b == imapcp_pkg::BYTE_RBRACE && lit_rem_ff != 16'h0) begin
               phase_in = imapcp_pkg::PH_LIT_OPEN;
            end else begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_INVALID;
               line_clear = 1'b1;
            end
         end

         imapcp_pkg::PH_LIT_OPEN: begin
            if (b == imapcp_pkg::BYTE_CR) begin
               phase_in = phase_ff;
            end else if (b != imapcp_pkg::BYTE_LF) begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_INVALID;
               line_clear = 1'b1;
            end else begin
               // Ask the client to send the literal bytes.
               arg_begin_in = pos_next;
               phase_in     = imapcp_pkg::PH_LIT_DATA;
               emit         = 1'b1;
               ev_kind      = imapcp_pkg::EV_CONTINUE;
            end
         end

         imapcp_pkg::PH_LIT_DATA: begin
            if (lit_rem_ff > 16'd1) begin
               lit_rem_in = lit_rem_ff - 16'd1;
            end else begin
               // Last literal byte closes the argument.
               lit_rem_in = '0;
               if (args_ff < 2'd3) begin
                  args_in = args_ff + 2'd1;
               end
               phase_in = imapcp_pkg::PH_LIT_END;
               emit     = 1'b1;
               ev_kind  = imapcp_pkg::EV_ARG;
               ev_arg   = 1'b1;
               ev_len   = lit_len;
            end
         end

         imapcp_pkg::PH_LIT_END: begin
            if (b == imapcp_pkg::BYTE_LBRACE) begin
               if (args_ff >= 2'(imapcp_pkg::MAX_ARGS)) begin
                  emit       = 1'b1;
                  ev_kind    = imapcp_pkg::EV_INVALID;
                  line_clear = 1'b1;
               end else begin
                  lit_rem_in = '0;
                  phase_in   = imapcp_pkg::PH_LIT_COUNT;
               end
            end else if (b == imapcp_pkg::BYTE_CR) begin
               phase_in = imapcp_pkg::PH_ALMOST;
            end else if (b == imapcp_pkg::BYTE_LF) begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_LINE;
               line_clear = 1'b1;
            end else begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_INVALID;
               line_clear = 1'b1;
            end
         end

         imapcp_pkg::PH_ALMOST: begin
            emit       = 1'b1;
            line_clear = 1'b1;
            ev_kind    = (b == imapcp_pkg::BYTE_LF) ? imapcp_pkg::EV_LINE
                                                    : imapcp_pkg::EV_INVALID;
         end

         default: begin
            // Tag phase; unused phase codes behave the same way.
            phase_in = imapcp_pkg::PH_TAG;
            if (b == imapcp_pkg::BYTE_SPACE) begin
               tag_len_in = pos_next;
               phase_in   = imapcp_pkg::PH_PRE_CMD;
            end else if (b == imapcp_pkg::BYTE_CR || b == imapcp_pkg::BYTE_LF) begin
               emit       = 1'b1;
               ev_kind    = imapcp_pkg::EV_INVALID;
               line_clear = 1'b1;
            end
         end
      endcase

      // Line end returns every piece of line state to its reset value.
      if (line_clear) begin
         phase_in      = imapcp_pkg::PH_TAG;
         pos_in        = '0;
         tag_len_in    = '0;
         letter_cnt_in = '0;
         matched_in    = imapcp_pkg::CMD_NOOP;
         quote_in      = 1'b0;
         lit_rem_in    = '0;
         arg_begin_in  = '0;
         args_in       = '0;
      end
   end

   // The command code of a line that ends right after the command comes
   // from this cycle's match.
   assign out_cmd = (phase_ff == imapcp_pkg::PH_CMD) ? match_code : matched_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_lit_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         max_lit_ff <= csr_wr_data;
      end
   end

   // Line state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= imapcp_pkg::PH_TAG;
         pos_ff        <= '0;
         tag_len_ff    <= '0;
         letter_cnt_ff <= '0;
         matched_ff    <= imapcp_pkg::CMD_NOOP;
         quote_ff      <= 1'b0;
         lit_rem_ff    <= '0;
         arg_begin_ff  <= '0;
         args_ff       <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         tag_len_ff    <= tag_len_in;
         letter_cnt_ff <= letter_cnt_in;
         matched_ff    <= matched_in;
         quote_ff      <= quote_in;
         lit_rem_ff    <= lit_rem_in;
         arg_begin_ff  <= arg_begin_in;
         args_ff       <= args_in;
      end
   end

   // Command letter store; the slot is the count before this letter.
   always_ff @(posedge clock) begin
      if (advance && letter_wr) begin
         if (phase_ff == imapcp_pkg::PH_PRE_CMD) begin
            letters_ff[0] <= b;
         end else begin
            letters_ff[letter_cnt_ff] <= b;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && emit;
      end
      if (advance && emit) begin
         ev_kind_ff     <= ev_kind;
         cmd_code_ff    <= (ev_kind == imapcp_pkg::EV_LINE) ? out_cmd
                                                            : imapcp_pkg::CMD_NOOP;
         tag_len_out_ff <= (ev_kind == imapcp_pkg::EV_LINE) ? tag_len_ff : '0;
         arg_valid_ff   <= ev_arg;
         arg_index_ff   <= ev_arg ? args_ff : 2'd0;
         arg_offset_ff  <= ev_arg ? arg_begin_ff : '0;
         arg_length_ff  <= ev_arg ? ev_len : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = ev_kind_ff;
   assign rsp_command_code = cmd_code_ff;
   assign rsp_tag_length   = tag_len_out_ff;
   assign rsp_arg_valid    = arg_valid_ff;
   assign rsp_arg_index    = arg_index_ff;
   assign rsp_arg_offset   = arg_offset_ff;
   assign rsp_arg_length   = arg_length_ff;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMAP command line parser testbench
// Streams command lines byte by byte into the parser: a directed set of
// lines for the corner cases, then random lines under several literal size
// limits and idle patterns. An in-bench parser predicts every event, and
// each event taken from the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   // One event as seen on the result channel, in port order.
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  command;
      logic [15:0] tag_length;
      logic        arg_valid;
      logic [1:0]  arg_index;
      logic [15:0] arg_offset;
      logic [15:0] arg_length;
   } line_event_type;

   // Tracks the parse of the byte stream and holds the events still due.
   class parse_tracker_type;
      logic [15:0]         max_literal;
      logic [3:0]          phase;
      imapcp_pkg::pos_type line_pos;
      imapcp_pkg::pos_type tag_len;
      imapcp_pkg::pos_type arg_first;
      logic [7:0]          letters[imapcp_pkg::MAX_LETTERS];
      int                  letter_cnt;
      logic [1:0]          cmd;
      bit                  quoted;
      int unsigned         lit_left;
      int                  n_args;
      line_event_type      expected_events[$];
      line_event_type      next_event;
      bit                  has_event;
      int                  failures;
      int                  bytes_seen;
      int                  kind_seen[4];

      function new();
         max_literal = 16'hFFFF;
         clear_line();
      endfunction

      function void set_max_literal(input logic [15:0] v);
         max_literal = v;
      endfunction

      function void clear_line();
         phase      = imapcp_pkg::PH_TAG;
         line_pos   = '0;
         tag_len    = '0;
         arg_first  = '0;
         letter_cnt = 0;
         cmd        = imapcp_pkg::CMD_NOOP;
         quoted     = 1'b0;
         lit_left   = 0;
         n_args     = 0;
      endfunction

      function imapcp_pkg::pos_type bump(input imapcp_pkg::pos_type v);
         return (v == imapcp_pkg::POS_MAX) ? imapcp_pkg::POS_MAX
                                           : v + imapcp_pkg::pos_type'(1);
      endfunction

      function void emit(input logic [1:0] k, input bit av, input logic [1:0] idx,
                         input imapcp_pkg::pos_type off, input imapcp_pkg::pos_type len);
         next_event.kind       = k;
         next_event.command    = (k == imapcp_pkg::EV_LINE) ? cmd : imapcp_pkg::CMD_NOOP;
         next_event.tag_length = (k == imapcp_pkg::EV_LINE) ? tag_len : '0;
         next_event.arg_valid  = av;
         next_event.arg_index  = av ? idx : 2'd0;
         next_event.arg_offset = av ? off : '0;
         next_event.arg_length = av ? len : '0;
         has_event = 1'b1;
      endfunction

      function void reject_line();
         clear_line();
         emit(imapcp_pkg::EV_INVALID, 1'b0, 2'd0, '0, '0);
      endfunction

      function void end_line(input bit av, input logic [1:0] idx,
                             input imapcp_pkg::pos_type off, input imapcp_pkg::pos_type len);
         emit(imapcp_pkg::EV_LINE, av, idx, off, len);
         clear_line();
      endfunction

      function void add_letter(input logic [7:0] b);
         if (letter_cnt < imapcp_pkg::MAX_LETTERS) letters[letter_cnt] = b;
         if (letter_cnt <= imapcp_pkg::MAX_LETTERS) letter_cnt++;
      endfunction

      // Case-insensitive compare; only entries below the count are read.
      function bit word_matches(input string w);
         if (letter_cnt != w.len()) return 1'b0;
         for (int i = 0; i < w.len(); i++) begin
            if ((letters[i] | 8'h20) != w[i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function bit match_command();
         if (word_matches("noop")) cmd = imapcp_pkg::CMD_NOOP;
         else if (word_matches("login")) cmd = imapcp_pkg::CMD_LOGIN;
         else if (word_matches("logout")) cmd = imapcp_pkg::CMD_LOGOUT;
         else if (word_matches("capability")) cmd = imapcp_pkg::CMD_CAPABILITY;
         else return 1'b0;
         return 1'b1;
      endfunction

      // Advances the parse by one accepted byte and queues its event, if any.
      function void note_byte(input logic [7:0] b);
         imapcp_pkg::pos_type p;
         imapcp_pkg::pos_type len;
         logic [1:0]          idx;
         int unsigned         v;
         bit                  closes;
         bit                  is_end;
         p = line_pos;
         line_pos = bump(p);
         has_event = 1'b0;
         bytes_seen++;
         is_end = (b == imapcp_pkg::BYTE_CR) || (b == imapcp_pkg::BYTE_LF);
         case (phase)
            imapcp_pkg::PH_PRE_CMD: begin
               if (is_end) begin
                  reject_line();
               end else if (b != imapcp_pkg::BYTE_SPACE) begin
                  letter_cnt = 0;
                  add_letter(b);
                  phase = imapcp_pkg::PH_CMD;
               end
            end
            imapcp_pkg::PH_CMD: begin
               if (b == imapcp_pkg::BYTE_SPACE || is_end) begin
                  if (!match_command()) reject_line();
                  else if (b == imapcp_pkg::BYTE_SPACE) phase = imapcp_pkg::PH_PRE_ARG;
                  else if (b == imapcp_pkg::BYTE_CR) phase = imapcp_pkg::PH_ALMOST;
                  else end_line(1'b0, 2'd0, '0, '0);
               end else if (!((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))) begin
                  reject_line();
               end else begin
                  add_letter(b);
               end
            end
            imapcp_pkg::PH_PRE_ARG: begin
               if (b == imapcp_pkg::BYTE_CR) begin
                  phase = imapcp_pkg::PH_ALMOST;
               end else if (b == imapcp_pkg::BYTE_LF) begin
                  end_line(1'b0, 2'd0, '0, '0);
               end else if (b != imapcp_pkg::BYTE_SPACE) begin
                  if (n_args >= imapcp_pkg::MAX_ARGS) begin
                     reject_line();
                  end else if (b == imapcp_pkg::BYTE_QUOTE) begin
                     quoted = 1'b1;
                     arg_first = bump(p);
                     phase = imapcp_pkg::PH_ARG;
                  end else if (b == imapcp_pkg::BYTE_LBRACE) begin
                     lit_left = 0;
                     phase = imapcp_pkg::PH_LIT_COUNT;
                  end else begin
                     arg_first = p;
                     phase = imapcp_pkg::PH_ARG;
                  end
               end
            end
            imapcp_pkg::PH_ARG: begin
               // A quote closes the argument only while the quote flag is set.
               closes = 1'b0;
               if (b == imapcp_pkg::BYTE_QUOTE) begin
                  if (quoted) begin
                     quoted = 1'b0;
                     closes = 1'b1;
                  end
               end else if (b == imapcp_pkg::BYTE_SPACE || is_end) begin
                  closes = 1'b1;
               end
               if (closes) begin
                  idx = n_args[1:0];
                  len = (p >= arg_first) ? p - arg_first : '0;
                  if (n_args < 3) n_args++;
                  if (b == imapcp_pkg::BYTE_LF) begin
                     end_line(1'b1, idx, arg_first, len);
                  end else begin
                     phase = (b == imapcp_pkg::BYTE_CR) ? imapcp_pkg::PH_ALMOST
                                                        : imapcp_pkg::PH_PRE_ARG;
                     emit(imapcp_pkg::EV_ARG, 1'b1, idx, arg_first, len);
                  end
               end
            end
            imapcp_pkg::PH_LIT_COUNT: begin
               if (b >= imapcp_pkg::BYTE_ZERO && b <= imapcp_pkg::BYTE_NINE) begin
                  v = lit_left * 10 + int'(b - imapcp_pkg::BYTE_ZERO);
                  if (v > max_literal) reject_line();
                  else lit_left = v;
               end else if (b == imapcp_pkg::BYTE_RBRACE && lit_left != 0) begin
                  phase = imapcp_pkg::PH_LIT_OPEN;
               end else begin
                  reject_line();
               end
            end
            imapcp_pkg::PH_LIT_OPEN: begin
               if (b == imapcp_pkg::BYTE_LF) begin
                  arg_first = bump(p);
                  phase = imapcp_pkg::PH_LIT_DATA;
                  emit(imapcp_pkg::EV_CONTINUE, 1'b0, 2'd0, '0, '0);
               end else if (b != imapcp_pkg::BYTE_CR) begin
                  reject_line();
               end
            end
            imapcp_pkg::PH_LIT_DATA: begin
               if (lit_left > 1) begin
                  lit_left--;
               end else begin
                  lit_left = 0;
                  idx = n_args[1:0];
                  len = bump(p);
                  len = (len >= arg_first) ? len - arg_first : '0;
                  if (n_args < 3) n_args++;
                  phase = imapcp_pkg::PH_LIT_END;
                  emit(imapcp_pkg::EV_ARG, 1'b1, idx, arg_first, len);
               end
            end
            imapcp_pkg::PH_LIT_END: begin
               if (b == imapcp_pkg::BYTE_LBRACE) begin
                  if (n_args >= imapcp_pkg::MAX_ARGS) begin
                     reject_line();
                  end else begin
                     lit_left = 0;
                     phase = imapcp_pkg::PH_LIT_COUNT;
                  end
               end else if (b == imapcp_pkg::BYTE_CR) begin
                  phase = imapcp_pkg::PH_ALMOST;
               end else if (b == imapcp_pkg::BYTE_LF) begin
                  end_line(1'b0, 2'd0, '0, '0);
               end else begin
                  reject_line();
               end
            end
            imapcp_pkg::PH_ALMOST: begin
               if (b == imapcp_pkg::BYTE_LF) end_line(1'b0, 2'd0, '0, '0);
               else reject_line();
            end
            default: begin
               phase = imapcp_pkg::PH_TAG;
               if (b == imapcp_pkg::BYTE_SPACE) begin
                  tag_len = bump(p);
                  phase = imapcp_pkg::PH_PRE_CMD;
               end else if (is_end) begin
                  reject_line();
               end
            end
         endcase
         if (has_event) expected_events.push_back(next_event);
      endfunction

      // Compares one event taken from the block with the oldest prediction.
      function void check_event(input line_event_type got);
         line_event_type want;
         if (expected_events.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Unexpected event: kind=%0d cmd=%0d tag=%0d arg=%0d/%0d/%0d/%0d",
                        got.kind, got.command, got.tag_length, got.arg_valid,
                        got.arg_index, got.arg_offset, got.arg_length);
            return;
         end
         want = expected_events.pop_front();
         kind_seen[want.kind]++;
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("Mismatch: expected kind=%0d cmd=%0d tag=%0d arg=%0d/%0d/%0d/%0d",
                        want.kind, want.command, want.tag_length, want.arg_valid,
                        want.arg_index, want.arg_offset, want.arg_length);
               $display("          got      kind=%0d cmd=%0d tag=%0d arg=%0d/%0d/%0d/%0d",
                        got.kind, got.command, got.tag_length, got.arg_valid,
                        got.arg_index, got.arg_offset, got.arg_length);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [1:0]  rsp_command_code;
   logic [15:0] rsp_tag_length;
   logic        rsp_arg_valid;
   logic [1:0]  rsp_arg_index;
   logic [15:0] rsp_arg_offset;
   logic [15:0] rsp_arg_length;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   parse_tracker_type sb = new();
   int           send_idle_pct = 17;
   int           recv_idle_pct = 50;
   logic [15:0]  cur_max = 16'hFFFF;
   logic [7:0]   line_bytes[$];

   imap_command_line_parser_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_command_code (rsp_command_code),
      .rsp_tag_length   (rsp_tag_length),
      .rsp_arg_valid    (rsp_arg_valid),
      .rsp_arg_index    (rsp_arg_index),
      .rsp_arg_offset   (rsp_arg_offset),
      .rsp_arg_length   (rsp_arg_length),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #10_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   // The receiver stalls at random, changing only at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
   end

   // Every transfer on the result channel is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_event(line_event_type'({rsp_event_kind, rsp_command_code,
                                          rsp_tag_length, rsp_arg_valid, rsp_arg_index,
                                          rsp_arg_offset, rsp_arg_length}));
   end

   // Offers one byte, with random idle cycles ahead of it, until it is taken.
   task automatic send_byte(input logic [7:0] b);
      bit taken;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         if (taken) sb.note_byte(b);
         @(negedge clock);
      end
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
   endtask

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endfunction

   task automatic send_text(input string s);
      line_bytes.delete();
      push_text(s);
      send_line();
   endtask

   // Holds the sender off until every predicted event has arrived.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_max_literal(input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_max_literal(v);
      cur_max = v;
   endtask

   // Random byte that is never a space, CR or LF, and optionally no quote
   // or opening brace either.
   function automatic logic [7:0] pick_byte(input bit plain_start, input bit no_quote);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == imapcp_pkg::BYTE_SPACE || b == imapcp_pkg::BYTE_CR ||
                 b == imapcp_pkg::BYTE_LF ||
                 (no_quote && b == imapcp_pkg::BYTE_QUOTE) ||
                 (plain_start && b == imapcp_pkg::BYTE_LBRACE));
      return b;
   endfunction

   function automatic void push_word_mixed_case(input string w);
      for (int i = 0; i < w.len(); i++)
         line_bytes.push_back($urandom_range(1) ? (w[i] & 8'hDF) : w[i]);
   endfunction

   function automatic void push_literal();
      int unsigned n;
      int unsigned cap;
      int          r;
      cap = (cur_max < 8) ? cur_max : 8;
      r = $urandom_range(99);
      if (r < 85) n = $urandom_range(1, cap);
      else if (r < 97) n = $urandom_range(0, 99);
      else n = cur_max + 1;
      line_bytes.push_back(imapcp_pkg::BYTE_LBRACE);
      if ($urandom_range(9) == 0) line_bytes.push_back(imapcp_pkg::BYTE_ZERO);
      push_text($sformatf("%0d", n));
      line_bytes.push_back(imapcp_pkg::BYTE_RBRACE);
      if ($urandom_range(1)) line_bytes.push_back(imapcp_pkg::BYTE_CR);
      line_bytes.push_back(imapcp_pkg::BYTE_LF);
      if (n >= 1 && n <= cur_max && n <= 99)
         repeat (n) line_bytes.push_back(8'($urandom_range(255)));
   endfunction

   // Builds one random line: mostly well formed with random content, the
   // rest noise or a well-formed line with one byte damaged.
   function automatic void compose_line();
      string words[4];
      int    r;
      int    n_arg;
      int    shape;
      bit    after_literal;
      words = '{"noop", "login", "logout", "capability"};
      line_bytes.delete();
      r = $urandom_range(99);
      if (r < 8) begin
         repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      // Tag, occasionally empty.
      if ($urandom_range(19) != 0)
         repeat ($urandom_range(1, 6)) line_bytes.push_back(pick_byte(1'b0, 1'b0));
      repeat ($urandom_range(1, 2)) line_bytes.push_back(imapcp_pkg::BYTE_SPACE);
      // Command word.
      r = $urandom_range(19);
      if (r < 16) begin
         push_word_mixed_case(words[r % 4]);
      end else if (r < 18) begin
         repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end else if (r == 18) begin
         push_word_mixed_case(words[$urandom_range(3)]);
         line_bytes[line_bytes.size() - 1 - $urandom_range(3)] = 8'($urandom_range(255));
      end
      // Arguments; a literal is mostly followed by another literal.
      n_arg = ($urandom_range(14) == 0) ? 4 : $urandom_range(0, 3);
      after_literal = 1'b0;
      for (int a = 0; a < n_arg; a++) begin
         shape = (after_literal && $urandom_range(4) != 0) ? 2 : $urandom_range(2);
         if (!(after_literal && shape == 2))
            repeat ($urandom_range(1, 2)) line_bytes.push_back(imapcp_pkg::BYTE_SPACE);
         case (shape)
            0: begin
               line_bytes.push_back(pick_byte(1'b1, 1'b1));
               repeat ($urandom_range(0, 6)) line_bytes.push_back(pick_byte(1'b0, 1'b0));
            end
            1: begin
               line_bytes.push_back(imapcp_pkg::BYTE_QUOTE);
               repeat ($urandom_range(0, 6)) line_bytes.push_back(pick_byte(1'b0, 1'b1));
               line_bytes.push_back(imapcp_pkg::BYTE_QUOTE);
            end
            default: push_literal();
         endcase
         after_literal = (shape == 2);
      end
      // Line end: CRLF, bare LF or a dangling CR.
      r = $urandom_range(19);
      if (r < 16) line_bytes.push_back(imapcp_pkg::BYTE_CR);
      if (r != 19) line_bytes.push_back(imapcp_pkg::BYTE_LF);
      else line_bytes.push_back(imapcp_pkg::BYTE_CR);
      if ($urandom_range(9) == 0)
         line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom_range(255));
   endfunction

   // Stimulus.
   initial begin
      logic [15:0] lit_limits[6];
      int          seg_start;
      lit_limits = '{16'hFFFF, 16'd1, 16'($urandom_range(2, 40)), 16'd12,
                     16'($urandom_range(1, 65535)), 16'hFFFF};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_max_literal(16'hFFFF);

      // Directed lines; "\015" is a CR byte.
      line_bytes.delete();
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      push_text("a NOOP\015\n");
      send_line();
      send_text("A2 login joe \"x y\"\015\n");
      send_text("a3 LogOut\n");
      send_text("a4 CAPABILITY\015\n");
      send_text("a5 login {3}\015\nabc{2}\nxy\015\n");
      send_text("a6 noop a b c d\015\n");
      send_text("a7 noop x y {1}\nz{1}\n\015\n");
      send_text("a8 login user pw\n");
      send_text("a9 \015\n");
      send_text("b1 NO1P\015\n");
      send_text("b2 NOPE\015\n");
      send_text("b3 CAPABILITYX\015\n");
      send_text("b4 login {x}\015\n");
      send_text("b5 login {0}\015\n");
      send_text("b6 login {65536}\015\n");
      send_text("b7 login {65535}x\015\n");
      send_text("b8 login {2}\015\015\nab!\015\n");
      send_text("b9 noop\015x\015\n");
      send_text("c1 login \"\" \"q\n");
      send_text("tagonly\015\n");
      send_text("  noop\n");

      // Random lines in six parts: three idle patterns, six literal limits.
      for (int seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg / 2 == 0) ? 17 : (seg / 2 == 1) ? 50 : 0;
         recv_idle_pct = (seg / 2 == 0) ? 50 : (seg / 2 == 1) ? 17 : 0;
         wait_for_idle();
         write_max_literal(lit_limits[seg]);
         seg_start = sb.bytes_seen;
         while (sb.bytes_seen - seg_start < 215) begin
            compose_line();
            send_line();
         end
      end

      // Drain and close out.
      wait_for_idle();
      repeat (8) @(posedge clock);
      if (sb.expected_events.size() != 0) begin
         sb.failures++;
         $display("Missing events: %0d predicted but never seen",
                  sb.expected_events.size());
      end
      $display("Run covered %0d bytes under six literal limits and three idle patterns:",
               sb.bytes_seen);
      $display("  %0d lines complete, %0d invalid, %0d arguments, %0d continuations",
               sb.kind_seen[imapcp_pkg::EV_LINE], sb.kind_seen[imapcp_pkg::EV_INVALID],
               sb.kind_seen[imapcp_pkg::EV_ARG], sb.kind_seen[imapcp_pkg::EV_CONTINUE]);
      if (sb.failures == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/imapcp_pkg.sv
hw/rtl/imap_command_line_parser_core.sv
bench/tb_top.sv
